// ----- hw/rtl/rgp_pkg.sv -----
// Package for the radial gradient pattern generator.
// Types, widths, register indexes and pipeline depths; no dependencies.
package rgp_pkg;

  localparam int CFG_W    = 13;
  localparam int IDX_W    = 2;
  localparam int PIX_W    = 12;
  localparam int SMP_W    = 32;
  localparam int COORD_W  = 17;
  localparam int SQ_W     = 36;
  localparam int ROOT_W   = 18;
  localparam int T_W      = 22;
  localparam int DVSR_W   = 20;
  localparam int HALF_W   = 19;
  localparam int NUM_W    = 54;
  localparam int NX_W     = 20;
  localparam int NYRG_W   = 22;

  localparam int SQRT_STAGES = 9;
  localparam int SQRT_STEPS  = 2;
  localparam int DIV_STAGES  = 16;
  localparam int DIV_STEPS   = 2;
  localparam int CH_LAT      = 3 + SQRT_STAGES + 2 + DIV_STAGES + 1;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEPTH  = 2'd2;

  typedef enum logic [1:0] {
    DEPTH_8    = 2'd0,
    DEPTH_16   = 2'd1,
    DEPTH_32   = 2'd2,
    DEPTH_NONE = 2'd3
  } depth_t;

  typedef struct packed {
    depth_t              depth;
    logic [DVSR_W-1:0]   dvsr;
    logic [HALF_W-1:0]   half;
  } rgp_scale_t;

  typedef struct packed {
    logic [SMP_W-1:0] red;
    logic [SMP_W-1:0] green;
    logic [SMP_W-1:0] blue;
  } rgp_rgb_t;

endpackage

// ----- hw/rtl/rgp_if.sv -----
// Valid/ready channels of the radial gradient pattern generator.
// Depends on rgp_pkg for field widths.
interface rgp_pix_if import rgp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_row;
  logic [PIX_W-1:0] pixel_col;
  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface rgp_rgb_if import rgp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] red_value;
  logic [SMP_W-1:0] green_value;
  logic [SMP_W-1:0] blue_value;
  modport source (output valid, output red_value, output green_value, output blue_value,
                  input ready);
  modport sink (input valid, input red_value, input green_value, input blue_value,
                output ready);
endinterface

// ----- hw/rtl/rgp_channel.sv -----
// One color channel: distance to its center, pipelined square root and
// pipelined restoring divide. Depends on rgp_pkg.
module rgp_channel import rgp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] px,
  input  logic [COORD_W-1:0] py,
  input  logic [COORD_W-1:0] cx,
  input  logic [COORD_W-1:0] cy,
  input  rgp_scale_t         scale,
  output logic [SMP_W-1:0]   sample
);

  logic [COORD_W-1:0]   dx_r, dy_r;
  logic [2*COORD_W-1:0] sx_r, sy_r;
  logic [SQ_W-1:0]      sum_r;
  logic [SQ_W-1:0]      rt_x_r   [SQRT_STAGES];
  logic [SQ_W-1:0]      rt_res_r [SQRT_STAGES];
  logic [T_W-1:0]       t_r;
  logic                 tsat_r;
  logic [NUM_W-1:0]     n_r;
  logic                 nsat_r;
  logic [DVSR_W-1:0]    dv_rem_r [DIV_STAGES];
  logic [SMP_W-1:0]     dv_low_r [DIV_STAGES];
  logic [SMP_W-1:0]     dv_q_r   [DIV_STAGES];
  logic                 dv_sat_r [DIV_STAGES];
  logic [SMP_W-1:0]     smp_r;
  logic [ROOT_W-1:0]    root;
  logic [T_W-1:0]       t_nxt;
  logic [NUM_W-1:0]     n_nxt;
  logic [SMP_W-1:0]     fs;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= (px >= cx) ? px - cx : cx - px;
      dy_r  <= (py >= cy) ? py - cy : cy - py;
      sx_r  <= dx_r * dx_r;
      sy_r  <= dy_r * dy_r;
      sum_r <= SQ_W'(sx_r) + SQ_W'(sy_r);
    end
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    logic [SQ_W-1:0] x_in, r_in, x_nxt, r_nxt;
    if (s == 0) begin : g_first
      assign x_in = sum_r;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = rt_x_r[s-1];
      assign r_in = rt_res_r[s-1];
    end
    always_comb begin
      logic [SQ_W-1:0] b;
      x_nxt = x_in;
      r_nxt = r_in;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        b = SQ_W'(1) << (2 * (SQRT_STAGES * SQRT_STEPS - 1 - SQRT_STEPS * s - j));
        if (x_nxt >= r_nxt + b) begin
          x_nxt = x_nxt - (r_nxt + b);
          r_nxt = (r_nxt >> 1) + b;
        end else begin
          r_nxt = r_nxt >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_x_r[s]   <= x_nxt;
        rt_res_r[s] <= r_nxt;
      end
    end
  end

  assign root  = rt_res_r[SQRT_STAGES-1][ROOT_W-1:0];
  assign t_nxt = (T_W'(root) << 3) + (T_W'(root) << 1);

  always_comb begin
    case (scale.depth)
      DEPTH_8:  n_nxt = NUM_W'(t_r) << 8;
      DEPTH_16: n_nxt = NUM_W'(t_r) << 16;
      DEPTH_32: n_nxt = NUM_W'(t_r) << 32;
      default:  n_nxt = '0;
    endcase
    n_nxt = n_nxt - NUM_W'(t_r) + NUM_W'(scale.half);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      tsat_r <= t_nxt >= T_W'(scale.dvsr);
      n_r    <= n_nxt;
      nsat_r <= tsat_r;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [DVSR_W-1:0] rem_in, rem_nxt;
    logic [SMP_W-1:0]  low_in, low_nxt, q_in, q_nxt;
    logic              sat_in;
    if (s == 0) begin : g_first
      assign rem_in = n_r[SMP_W +: DVSR_W];
      assign low_in = n_r[SMP_W-1:0];
      assign q_in   = '0;
      assign sat_in = nsat_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[s-1];
      assign low_in = dv_low_r[s-1];
      assign q_in   = dv_q_r[s-1];
      assign sat_in = dv_sat_r[s-1];
    end
    always_comb begin
      logic [DVSR_W:0] r2;
      rem_nxt = rem_in;
      low_nxt = low_in;
      q_nxt   = q_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        r2      = {rem_nxt, low_nxt[SMP_W-1]};
        low_nxt = low_nxt << 1;
        if (r2 >= (DVSR_W+1)'(scale.dvsr)) begin
          rem_nxt = DVSR_W'(r2 - (DVSR_W+1)'(scale.dvsr));
          q_nxt   = {q_nxt[SMP_W-2:0], 1'b1};
        end else begin
          rem_nxt = r2[DVSR_W-1:0];
          q_nxt   = {q_nxt[SMP_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[s] <= rem_nxt;
        dv_low_r[s] <= low_nxt;
        dv_q_r[s]   <= q_nxt;
        dv_sat_r[s] <= sat_in;
      end
    end
  end

  always_comb begin
    case (scale.depth)
      DEPTH_8:  fs = SMP_W'(32'h0000_00FF);
      DEPTH_16: fs = SMP_W'(32'h0000_FFFF);
      DEPTH_32: fs = SMP_W'(32'hFFFF_FFFF);
      default:  fs = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r <= (dv_sat_r[DIV_STAGES-1] || scale.depth == DEPTH_NONE) ? '0 :
               fs - dv_q_r[DIV_STAGES-1];
    end
  end

  assign sample = smp_r;

endmodule

// ----- hw/rtl/radial_gradient_pattern_generator.sv -----
// Radial gradient pattern generator, top level. Depends on rgp_pkg, rgp_if, rgp_channel.
// Throughput one item per cycle while the output skid register is empty; ready is low while it is full.
// Each channel holds a pipelined square root (9 stages) and divide (16 stages).
// A skid register at the output keeps the pipeline full while the sink stalls.
// Reset (synchronous, active low) loads width 640, height 480, 8-bit depth and
// clears all valid bits.
module radial_gradient_pattern_generator import rgp_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  rgp_pix_if.sink          in_ch,
  rgp_rgb_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LAT = 2 + CH_LAT;

  logic [CFG_W-1:0]   width_r, height_r;
  depth_t             depth_r;
  logic [CFG_W-1:0]   w_eff, h_eff, m_eff;
  logic [NX_W-1:0]    nx_red_r, nx_grn_r, ny_blu_r;
  logic [NYRG_W-1:0]  ny_rg_r;
  logic [COORD_W-1:0] cx_red_r, cx_grn_r, cx_blu_r, cy_rg_r, cy_blu_r;
  rgp_scale_t         scale_r;
  logic [COORD_W-1:0] px0_r, py0_r, px1_r, py1_r;
  logic [LAT-1:0]     vld_r;
  logic               en, in_acc, pv, out_take;
  rgp_rgb_t           pdat, out_dat_r, skid_dat_r;
  logic               out_vld_r, skid_vld_r;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
    if (d == '0) return CFG_W'(1);
    if (int'(d) > MAX_DIM) return CFG_W'(MAX_DIM);
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
      depth_r  <= DEPTH_8;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_DEPTH:  depth_r  <= depth_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  assign w_eff = eff_dim(width_r);
  assign h_eff = eff_dim(height_r);
  assign m_eff = (w_eff >= h_eff) ? w_eff : h_eff;

  // centers in 1/16 pixel, rounded half up; divide by 10 and 50 by reciprocal
  always_ff @(posedge clk) begin
    nx_red_r      <= NX_W'(w_eff) * NX_W'(88) + NX_W'(5);
    nx_grn_r      <= NX_W'(w_eff) * NX_W'(72) + NX_W'(5);
    ny_blu_r      <= NX_W'(h_eff) * NX_W'(88) + NX_W'(5);
    ny_rg_r       <= NYRG_W'(h_eff) * NYRG_W'(376) + NYRG_W'(25);
    cx_blu_r      <= COORD_W'({w_eff, 3'b000});
    scale_r.depth <= depth_r;
    scale_r.dvsr  <= DVSR_W'(m_eff) * DVSR_W'(96);
    scale_r.half  <= HALF_W'(m_eff) * HALF_W'(48);
    cx_red_r      <= COORD_W'((64'(nx_red_r) * 64'(32'hCCCC_CCCD)) >> 35);
    cx_grn_r      <= COORD_W'((64'(nx_grn_r) * 64'(32'hCCCC_CCCD)) >> 35);
    cy_blu_r      <= COORD_W'((64'(ny_blu_r) * 64'(32'hCCCC_CCCD)) >> 35);
    cy_rg_r       <= COORD_W'((64'(ny_rg_r) * 64'(32'h51EB_851F)) >> 36);
  end

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;
  assign pv          = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r <= COORD_W'({in_ch.pixel_col, 4'b1000});
      py0_r <= COORD_W'({in_ch.pixel_row, 4'b1000});
      px1_r <= px0_r;
      py1_r <= py0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  rgp_channel u_red (
    .clk(clk), .en(en), .px(px1_r), .py(py1_r), .cx(cx_red_r), .cy(cy_rg_r),
    .scale(scale_r), .sample(pdat.red)
  );

  rgp_channel u_green (
    .clk(clk), .en(en), .px(px1_r), .py(py1_r), .cx(cx_grn_r), .cy(cy_rg_r),
    .scale(scale_r), .sample(pdat.green)
  );

  rgp_channel u_blue (
    .clk(clk), .en(en), .px(px1_r), .py(py1_r), .cx(cx_blu_r), .cy(cy_blu_r),
    .scale(scale_r), .sample(pdat.blue)
  );

  assign out_take = out_ch.ready || !out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= pv;
      end
    end else if (pv && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_dat_r <= skid_vld_r ? skid_dat_r : pdat;
    end else if (en) begin
      skid_dat_r <= pdat;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.red_value   = out_dat_r.red;
  assign out_ch.green_value = out_dat_r.green;
  assign out_ch.blue_value  = out_dat_r.blue;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the radial gradient pattern generator: drives pixel positions
// under random idling, predicts each RGB item in fixed point and checks it.
// Depends on rgp_pkg, rgp_if and the radial_gradient_pattern_generator RTL.
module tb;
  import rgp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = 34;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  rgp_pix_if pix ();
  rgp_rgb_if rgb ();

  radial_gradient_pattern_generator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(pix.sink), .out_ch(rgb.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CFG_W-1:0] gen_w, gen_h;
  depth_t gen_depth;
  rgp_rgb_t pending_rgb[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] channel_level(longint unsigned px, longint unsigned py,
      longint unsigned cx, longint unsigned cy, longint unsigned fs, longint unsigned m);
    longint unsigned dx, dy, d16, v;
    dx = px >= cx ? px - cx : cx - px;
    dy = py >= cy ? py - cy : cy - py;
    d16 = int_sqrt(dx * dx + dy * dy);
    v = (10 * d16 * fs + 48 * m) / (96 * m);
    if (v > fs) v = fs;
    return 32'(fs - v);
  endfunction

  function automatic longint unsigned clamp_dim(logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > 4096) return 4096;
    return d;
  endfunction

  function automatic rgp_rgb_t gradient_at(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
    rgp_rgb_t r;
    longint unsigned w, h, m, fs, px, py, cyrg;
    w = clamp_dim(gen_w);
    h = clamp_dim(gen_h);
    m = w >= h ? w : h;
    r = '0;
    case (gen_depth)
      DEPTH_8: fs = 64'hFF;
      DEPTH_16: fs = 64'hFFFF;
      DEPTH_32: fs = 64'hFFFF_FFFF;
      default: return r;
    endcase
    px = 16 * longint'(col) + 8;
    py = 16 * longint'(row) + 8;
    cyrg = (376 * h + 25) / 50;
    r.red = channel_level(px, py, (176 * w + 10) / 20, cyrg, fs, m);
    r.green = channel_level(px, py, (144 * w + 10) / 20, cyrg, fs, m);
    r.blue = channel_level(px, py, 8 * w, (176 * h + 10) / 20, fs, m);
    return r;
  endfunction

  always @(posedge clk) begin
    rgb.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && rgb.valid && rgb.ready) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected item r=%h g=%h b=%h", $time,
                 rgb.red_value, rgb.green_value, rgb.blue_value);
        errors++;
      end else begin
        rgp_rgb_t e;
        e = pending_rgb.pop_front();
        if (rgb.red_value !== e.red) begin
          $display("%0t: red expected %h actual %h", $time, e.red, rgb.red_value);
          errors++;
        end
        if (rgb.green_value !== e.green) begin
          $display("%0t: green expected %h actual %h", $time, e.green, rgb.green_value);
          errors++;
        end
        if (rgb.blue_value !== e.blue) begin
          $display("%0t: blue expected %h actual %h", $time, e.blue, rgb.blue_value);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_row <= row;
    pix.pixel_col <= col;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pending_rgb.push_back(gradient_at(row, col));
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    pix.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH: gen_w = val;
      REG_HEIGHT: gen_h = val;
      default: gen_depth = depth_t'(val[1:0]);
    endcase
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, depth_t d);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_DEPTH, CFG_W'(d));
  endtask

  task automatic test_reset_frame();
    send_pixel('0, '0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd225, 12'd351);
    send_pixel(12'd263, 12'd288);
    send_pixel(12'd479, 12'd639);
  endtask

  task automatic test_depths_and_dims();
    set_frame(13'd640, 13'd480, DEPTH_16);
    send_pixel(12'd225, 12'd351);
    send_pixel(12'd4095, '0);
    set_frame(13'd1920, 13'd1080, DEPTH_32);
    send_pixel(12'd507, 12'd1055);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'hAAA, 12'h555);
    set_frame(13'd0, 13'd0, DEPTH_8);
    send_pixel('0, '0);
    send_pixel(12'd1, 12'd2);
    set_frame(13'h1FFF, 13'd4097, DEPTH_32);
    send_pixel(12'd2047, 12'd2047);
    send_pixel('0, 12'd4095);
    set_frame(13'd4096, 13'd1, DEPTH_NONE);
    send_pixel(12'd100, 12'd100);
    send_pixel(12'hFFF, 12'hFFF);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        set_frame($urandom_range(3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 300)),
                  $urandom_range(3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 300)),
                  depth_t'($urandom_range(3)));
      end
      if ($urandom_range(3) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range(gen_h > 0 ? gen_h : 1)),
                      12'($urandom_range(gen_w > 0 ? gen_w : 1)));
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_row = '0;
    pix.pixel_col = '0;
    gen_w = 13'd640;
    gen_h = 13'd480;
    gen_depth = DEPTH_8;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 53;
    test_reset_frame();
    test_depths_and_dims();
    test_random(130);
    send_idle_pct = 53;
    recv_idle_pct = 38;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(140);
    pix.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/rgp_pkg.sv
hw/rtl/rgp_if.sv
hw/rtl/rgp_channel.sv
hw/rtl/radial_gradient_pattern_generator.sv
tb/sv/tb.sv
